// ===== design/hbd_pkg.sv =====
// ---------------------------------------------------------------------------
// hbd_pkg: shared types and constants of the handheld bus decoder
// Transaction structs, target and mapper codes, register indexes, FSM states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        lcd_enabled;
    logic [1:0]  pix_mode;
    logic        vram_bank_select;
    logic [2:0]  wram_bank_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [22:0] physical_offset;
    logic [7:0]  fixed_read_value;
  } out_item_t;

  // Target codes
  localparam logic [3:0] TGT_NONE   = 4'd0;
  localparam logic [3:0] TGT_BOOT   = 4'd1;
  localparam logic [3:0] TGT_ROM    = 4'd2;
  localparam logic [3:0] TGT_VRAM   = 4'd3;
  localparam logic [3:0] TGT_CRAM   = 4'd4;
  localparam logic [3:0] TGT_WRAM   = 4'd5;
  localparam logic [3:0] TGT_OAM    = 4'd6;
  localparam logic [3:0] TGT_IO     = 4'd7;
  localparam logic [3:0] TGT_HRAM   = 4'd8;
  localparam logic [3:0] TGT_IE     = 4'd9;
  localparam logic [3:0] TGT_MAPPER = 4'd10;

  // Mapper types
  localparam logic [1:0] MAP_NONE = 2'd0;
  localparam logic [1:0] MAP_MBC1 = 2'd1;
  localparam logic [1:0] MAP_MBC5 = 2'd2;

  // Operations
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAPPER_TYPE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROM_BANK_COUNT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CART_RAM_BYTES   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOT_OVERLAY_ON  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOT_IMAGE_BYTES = 3'd4;

  // Saturation limits
  localparam logic [9:0]  MAX_ROM_BANKS      = 10'd512;
  localparam logic [17:0] MAX_CART_RAM_BYTES = 18'd131072;

  // Fixed read values
  localparam logic [7:0] FIX_BLOCKED  = 8'hff;
  localparam logic [7:0] FIX_UNUSABLE = 8'h00;

  // Remainder unit: dividend width, bits retired per cycle, number of steps
  localparam int unsigned DIV_W     = 18;
  localparam int unsigned DIV_STEPS = 6;
  localparam int unsigned DIV_ITERS = DIV_W / DIV_STEPS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic div_last;
    logic slot_free;
  } dp_sts_t;

endpackage : hbd_pkg

`default_nettype wire

// ===== design/handheld_bus_decoder_with_mapper_core.sv =====
// ---------------------------------------------------------------------------
// handheld_bus_decoder_with_mapper_core: CPU bus decoder with cartridge mapper
// Decodes one bus transaction into target memory, offset and fixed read value.
// ---------------------------------------------------------------------------
// in_*  : one bus transaction per handshake (operation, address, data and the
//         display/bank context). Writes below 0x8000 update the mapper.
// out_* : one result per transaction, in order, held in an output register
//         until out_ready; a new transaction is taken while it waits.
// cfg_* : register writes (index, data), always ready; write only when idle.
// Most transactions pass from the idle state through DIV to OUT and into the
//   output register; the next is accepted once the sequencer is idle again.
//   Banked ROM reads (0x4000-0x7fff) and enabled cartridge RAM accesses run the
//   shared remainder unit in DIV, 6 bits a cycle over 18 bits, before OUT.
// A stalled receiver holds one result; the sequencer then waits with the next
//   decoded before loading it, and in_ready stays low.
// Reset: synchronous, active low; mapper set to ROM bank 1, RAM bank 0,
//   RAM disabled; registers return to their defaults; output empties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module handheld_bus_decoder_with_mapper_core
  import hbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  hbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule : handheld_bus_decoder_with_mapper_core

`default_nettype wire

// ===== design/hbd_ctrl.sv =====
// ---------------------------------------------------------------------------
// hbd_ctrl: transaction sequencer
// Accepts one access, waits on the remainder unit, hands off to the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbd_ctrl
  import hbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.need_mod || sts.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = sts.need_mod;
      end
      ST_OUT: begin
        cmd.load_out = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule : hbd_ctrl

`default_nettype wire

// ===== design/hbd_dp.sv =====
// ---------------------------------------------------------------------------
// hbd_dp: decode datapath
// Region decode, mapper registers, configuration, shared remainder unit and
// the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbd_dp
  import hbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire ctl_cmd_t              cmd,
  output dp_sts_t                    sts
);

  localparam int unsigned CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITERS - 1);

  // Configuration
  logic [1:0]  map_type_r;
  logic [9:0]  bank_cnt_r;
  logic [17:0] ram_bytes_r;
  logic        boot_on_r;
  logic [11:0] boot_bytes_r;

  // Mapper state
  logic [8:0]  prg_bnk_r, prg_bnk_nxt;
  logic [3:0]  cram_bnk_r, cram_bnk_nxt;
  logic        cram_en_r, cram_en_nxt;

  // Decoded transaction
  logic [3:0]  tgt_r, tgt_nxt;
  logic [22:0] off_r, off_nxt;
  logic [7:0]  fix_r, fix_nxt;
  logic        need_mod_r, need_mod_nxt;
  logic        mod_rom_r, mod_rom_nxt;

  // Remainder unit
  logic [DIV_W-1:0] dvd_r, dvd_nxt, dvd_ld;
  logic [DIV_W-1:0] dvs_r, dvs_ld;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;

  // Output register
  logic        out_valid_r;
  out_item_t   out_data_r;

  // Saturated sizes
  logic [9:0]  banks_sat;
  logic [17:0] size_sat;

  always_comb begin
    if (bank_cnt_r == 10'd0) begin
      banks_sat = 10'd1;
    end else if (bank_cnt_r > MAX_ROM_BANKS) begin
      banks_sat = MAX_ROM_BANKS;
    end else begin
      banks_sat = bank_cnt_r;
    end
    size_sat = (ram_bytes_r > MAX_CART_RAM_BYTES) ? MAX_CART_RAM_BYTES : ram_bytes_r;
  end

  // Region decode of the incoming transaction
  always_comb begin
    logic [15:0] a;
    logic [2:0]  wb;
    a            = in_data.address;
    wb           = (in_data.wram_bank_select == 3'd0) ? 3'd1 : in_data.wram_bank_select;
    tgt_nxt      = TGT_NONE;
    off_nxt      = '0;
    fix_nxt      = FIX_UNUSABLE;
    need_mod_nxt = 1'b0;
    mod_rom_nxt  = 1'b0;
    dvd_ld       = '0;
    dvs_ld       = '0;

    // echo of work RAM
    if (a >= 16'he000 && a < 16'hfe00) a = a - 16'h2000;

    if (a < 16'h8000) begin
      if (in_data.operation == OP_WRITE) begin
        tgt_nxt = TGT_MAPPER;
        off_nxt = {7'd0, a};
      end else if (boot_on_r && (a < 16'h0100 || (a >= 16'h0200 && a < 16'h0900)) &&
                   a < {4'd0, boot_bytes_r}) begin
        tgt_nxt = TGT_BOOT;
        off_nxt = {7'd0, a};
      end else begin
        tgt_nxt = TGT_ROM;
        if (a < 16'h4000) begin
          off_nxt = {7'd0, a};
        end else begin
          off_nxt      = {9'd0, a[13:0]};
          need_mod_nxt = 1'b1;
          mod_rom_nxt  = 1'b1;
          dvd_ld       = {9'd0, prg_bnk_r};
          dvs_ld       = {8'd0, banks_sat};
        end
      end
    end else if (a < 16'ha000) begin
      if (in_data.lcd_enabled && in_data.pix_mode == 2'd3) begin
        fix_nxt = FIX_BLOCKED;
      end else begin
        tgt_nxt = TGT_VRAM;
        off_nxt = {9'd0, in_data.vram_bank_select, a[12:0]};
      end
    end else if (a < 16'hc000) begin
      if (!cram_en_r || size_sat == 18'd0) begin
        fix_nxt = FIX_BLOCKED;
      end else begin
        tgt_nxt      = TGT_CRAM;
        need_mod_nxt = 1'b1;
        dvd_ld       = {1'b0, cram_bnk_r, a[12:0]};
        dvs_ld       = size_sat;
      end
    end else if (a < 16'hd000) begin
      tgt_nxt = TGT_WRAM;
      off_nxt = {11'd0, a[11:0]};
    end else if (a < 16'he000) begin
      tgt_nxt = TGT_WRAM;
      off_nxt = {8'd0, wb, a[11:0]};
    end else if (a < 16'hfea0) begin
      tgt_nxt = TGT_OAM;
      off_nxt = {15'd0, a[7:0]};
    end else if (a < 16'hff00) begin
      fix_nxt = FIX_UNUSABLE;
    end else if (a < 16'hff80) begin
      tgt_nxt = TGT_IO;
      off_nxt = {16'd0, a[6:0]};
    end else if (a < 16'hffff) begin
      tgt_nxt = TGT_HRAM;
      off_nxt = {16'd0, a[6:0]};
    end else begin
      tgt_nxt = TGT_IE;
    end
  end

  // Mapper register writes
  always_comb begin
    logic [15:0] a;
    logic [7:0]  v;
    a            = in_data.address;
    v            = in_data.write_data;
    prg_bnk_nxt  = prg_bnk_r;
    cram_bnk_nxt = cram_bnk_r;
    cram_en_nxt  = cram_en_r;
    if (in_data.operation == OP_WRITE && a < 16'h8000) begin
      case (map_type_r)
        MAP_MBC5: begin
          if (a < 16'h2000) begin
            cram_en_nxt = (v[3:0] == 4'ha);
          end else if (a < 16'h3000) begin
            prg_bnk_nxt = {prg_bnk_r[8], v};
          end else if (a < 16'h4000) begin
            prg_bnk_nxt = {v[0], prg_bnk_r[7:0]};
          end else if (a < 16'h6000) begin
            cram_bnk_nxt = v[3:0];
          end
        end
        MAP_MBC1: begin
          if (a < 16'h2000) begin
            cram_en_nxt = (v[3:0] == 4'ha);
          end else if (a < 16'h4000) begin
            prg_bnk_nxt = (v[4:0] == 5'd0) ? 9'd1 : {4'd0, v[4:0]};
          end else if (a < 16'h6000) begin
            cram_bnk_nxt = {2'd0, v[1:0]};
          end
        end
        default: begin
          prg_bnk_nxt = prg_bnk_r;
        end
      endcase
    end
  end

  // Restoring remainder, DIV_STEPS bits per cycle
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int j = 0; j < DIV_STEPS; j++) begin
      t = {r, d[DIV_W-1]};
      if (t >= {1'b0, dvs_r}) t = t - {1'b0, dvs_r};
      r = t[DIV_W-1:0];
      d = {d[DIV_W-2:0], 1'b0};
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_type_r   <= MAP_NONE;
      bank_cnt_r   <= 10'd2;
      ram_bytes_r  <= 18'd0;
      boot_on_r    <= 1'b1;
      boot_bytes_r <= 12'd2304;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_MAPPER_TYPE:      map_type_r   <= cfg_wdata[1:0];
        CFG_ROM_BANK_COUNT:   bank_cnt_r   <= cfg_wdata[9:0];
        CFG_CART_RAM_BYTES:   ram_bytes_r  <= cfg_wdata[17:0];
        CFG_BOOT_OVERLAY_ON:  boot_on_r    <= cfg_wdata[0];
        CFG_BOOT_IMAGE_BYTES: boot_bytes_r <= cfg_wdata[11:0];
        default:              map_type_r   <= map_type_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bnk_r  <= 9'd1;
      cram_bnk_r <= 4'd0;
      cram_en_r  <= 1'b0;
    end else if (cmd.accept) begin
      prg_bnk_r  <= prg_bnk_nxt;
      cram_bnk_r <= cram_bnk_nxt;
      cram_en_r  <= cram_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tgt_r      <= tgt_nxt;
      off_r      <= off_nxt;
      fix_r      <= fix_nxt;
      need_mod_r <= need_mod_nxt;
      mod_rom_r  <= mod_rom_nxt;
      dvd_r      <= dvd_ld;
      dvs_r      <= dvs_ld;
      rem_r      <= '0;
      cnt_r      <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register: hold until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.target           <= tgt_r;
      out_data_r.fixed_read_value <= fix_r;
      if (!need_mod_r) begin
        out_data_r.physical_offset <= off_r;
      end else if (mod_rom_r) begin
        out_data_r.physical_offset <= {rem_r[8:0], off_r[13:0]};
      end else begin
        out_data_r.physical_offset <= {6'd0, rem_r[16:0]};
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.need_mod  = need_mod_r;
  assign sts.div_last  = (cnt_r == CNT_LAST);
  assign sts.slot_free = !out_valid_r || out_ready;

endmodule : hbd_dp

`default_nettype wire

// ===== design/hbd_checker.sv =====
// ---------------------------------------------------------------------------
// hbd_checker: port-level checks for the bus decoder
// Output hold under stall, one transaction at a time, result field rules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbd_checker
  import hbd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_fixed_only_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.target == TGT_NONE || out_data.fixed_read_value == 8'h00))
    else $error("fixed read value set on a mapped target");

  a_mapper_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.target == TGT_MAPPER || out_data.target == TGT_IE) |->
      out_data.physical_offset[22:15] == 8'd0)
    else $error("mapper or IE offset out of range");

endmodule : hbd_checker

bind handheld_bus_decoder_with_mapper_core hbd_checker u_hbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== dv/tb_handheld_bus_decoder_with_mapper_core.sv =====
// ---------------------------------------------------------------------------
// tb_handheld_bus_decoder_with_mapper_core: bus decoder and mapper testbench
// The testbench drives bus transactions through the decoder under a series of
// register settings, with random sender gaps and receiver stalls. An internal
// decoder and mapper model predicts each result, and the result is compared
// field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import hbd_pkg::*;

class decode_scoreboard;
  // register copy
  logic [1:0]  mapper_type;
  logic [9:0]  bank_total;
  logic [17:0] cart_ram_bytes;
  logic        boot_overlay_on;
  logic [11:0] boot_image_bytes;
  // mapper copy
  logic [8:0]  prg_bnk;
  logic [3:0]  cram_bnk;
  logic        cram_on;

  out_item_t   pending_decodes[$];
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned target_seen[16];

  function new();
    mapper_type      = MAP_NONE;
    bank_total       = 10'd2;
    cart_ram_bytes   = 18'd0;
    boot_overlay_on  = 1'b1;
    boot_image_bytes = 12'd2304;
    prg_bnk          = 9'd1;
    cram_bnk         = 4'd0;
    cram_on          = 1'b0;
    n_errors         = 0;
    n_checked        = 0;
    foreach (target_seen[i]) target_seen[i] = 0;
  endfunction

  function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MAPPER_TYPE:      mapper_type      = val[1:0];
      CFG_ROM_BANK_COUNT:   bank_total       = val[9:0];
      CFG_CART_RAM_BYTES:   cart_ram_bytes   = val[17:0];
      CFG_BOOT_OVERLAY_ON:  boot_overlay_on  = val[0];
      CFG_BOOT_IMAGE_BYTES: boot_image_bytes = val[11:0];
      default: ;
    endcase
  endfunction

  function void apply_mapper_write(int unsigned addr, logic [7:0] v);
    case (mapper_type)
      MAP_MBC5: begin
        if (addr < 'h2000) cram_on = (v[3:0] == 4'ha);
        else if (addr < 'h3000) prg_bnk = {prg_bnk[8], v};
        else if (addr < 'h4000) prg_bnk = {v[0], prg_bnk[7:0]};
        else if (addr < 'h6000) cram_bnk = v[3:0];
      end
      MAP_MBC1: begin
        if (addr < 'h2000) cram_on = (v[3:0] == 4'ha);
        else if (addr < 'h4000) prg_bnk = (v[4:0] == 5'd0) ? 9'd1 : {4'd0, v[4:0]};
        else if (addr < 'h6000) cram_bnk = {2'd0, v[1:0]};
      end
      default: ;
    endcase
  endfunction

  function out_item_t decode_access(in_item_t acc);
    out_item_t   res;
    int unsigned addr;
    int unsigned off;
    int unsigned banks;
    int unsigned ram_size;
    int unsigned wbank;
    res.target           = TGT_NONE;
    res.fixed_read_value = FIX_UNUSABLE;
    off                  = 0;
    addr                 = acc.address;
    // echo region folds onto work RAM
    if (addr >= 'he000 && addr < 'hfe00) addr = addr - 'h2000;
    if (addr < 'h8000) begin
      if (acc.operation == OP_WRITE) begin
        apply_mapper_write(addr, acc.write_data);
        res.target = TGT_MAPPER;
        off        = addr;
      end else if (boot_overlay_on && (addr < 'h100 || (addr >= 'h200 && addr < 'h900)) &&
                   addr < boot_image_bytes) begin
        res.target = TGT_BOOT;
        off        = addr;
      end else begin
        banks = bank_total;
        if (banks == 0) banks = 1;
        if (banks > MAX_ROM_BANKS) banks = MAX_ROM_BANKS;
        res.target = TGT_ROM;
        if (addr < 'h4000) off = addr;
        else off = ((int'(prg_bnk) % banks) << 14) | (addr & 'h3fff);
      end
    end else if (addr < 'ha000) begin
      if (acc.lcd_enabled && acc.pix_mode == 2'd3) begin
        res.fixed_read_value = FIX_BLOCKED;
      end else begin
        res.target = TGT_VRAM;
        off        = (int'(acc.vram_bank_select) << 13) | (addr - 'h8000);
      end
    end else if (addr < 'hc000) begin
      ram_size = cart_ram_bytes;
      if (ram_size > MAX_CART_RAM_BYTES) ram_size = MAX_CART_RAM_BYTES;
      if (!cram_on || ram_size == 0) begin
        res.fixed_read_value = FIX_BLOCKED;
      end else begin
        res.target = TGT_CRAM;
        off        = ((int'(cram_bnk) << 13) | (addr - 'ha000)) % ram_size;
      end
    end else if (addr < 'hd000) begin
      res.target = TGT_WRAM;
      off        = addr - 'hc000;
    end else if (addr < 'he000) begin
      wbank      = (acc.wram_bank_select == 3'd0) ? 1 : acc.wram_bank_select;
      res.target = TGT_WRAM;
      off        = (wbank << 12) | (addr - 'hd000);
    end else if (addr < 'hfea0) begin
      res.target = TGT_OAM;
      off        = addr - 'hfe00;
    end else if (addr < 'hff00) begin
      res.fixed_read_value = FIX_UNUSABLE;
    end else if (addr < 'hff80) begin
      res.target = TGT_IO;
      off        = addr & 'h7f;
    end else if (addr < 'hffff) begin
      res.target = TGT_HRAM;
      off        = addr - 'hff80;
    end else begin
      res.target = TGT_IE;
    end
    res.physical_offset = off[22:0];
    return res;
  endfunction

  function void note_access(in_item_t acc);
    pending_decodes.push_back(decode_access(acc));
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_decodes.size() == 0) begin
      $error("unexpected result: target %0d offset 0x%0h", got.target, got.physical_offset);
      n_errors++;
      return;
    end
    want = pending_decodes.pop_front();
    n_checked++;
    target_seen[want.target]++;
    if (got.target !== want.target) begin
      $error("target: expected %0d, got %0d", want.target, got.target);
      n_errors++;
    end
    if (got.physical_offset !== want.physical_offset) begin
      $error("physical_offset: expected 0x%0h, got 0x%0h",
             want.physical_offset, got.physical_offset);
      n_errors++;
    end
    if (got.fixed_read_value !== want.fixed_read_value) begin
      $error("fixed_read_value: expected 0x%0h, got 0x%0h",
             want.fixed_read_value, got.fixed_read_value);
      n_errors++;
    end
  endfunction

  function int unsigned pending();
    return pending_decodes.size();
  endfunction
endclass

module tb_handheld_bus_decoder_with_mapper_core;

  localparam int CLK_PERIOD    = 10;
  localparam int TIMEOUT_NS    = 2_000_000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 70;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  decode_scoreboard sb = new();

  rx_mode_e    rx_mode;
  int unsigned hold_cycles;
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned accesses_sent;
  int unsigned settings_applied;

  handheld_bus_decoder_with_mapper_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // check the oldest prediction first, then predict the newly accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_access(in_data);
    end
  end

  // receiver: stall pattern of its own, plus a long hold when asked
  initial begin
    int unsigned rx_tick;
    rx_tick   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_cycles != 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        case (rx_mode)
          RX_RANDOM:  out_ready = ($urandom_range(0, 9) < 7);
          RX_PATTERN: out_ready = ((rx_tick % 11) >= 3);
          default:    out_ready = 1'b1;
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_item_t bus_access(logic op, logic [15:0] addr, logic [7:0] data,
                                          logic lcd, logic [1:0] mode, logic vb,
                                          logic [2:0] ws);
    in_item_t it;
    it.operation        = op;
    it.address          = addr;
    it.write_data       = data;
    it.lcd_enabled      = lcd;
    it.pix_mode         = mode;
    it.vram_bank_select = vb;
    it.wram_bank_select = ws;
    return it;
  endfunction

  function automatic in_item_t random_context(logic op, logic [15:0] addr, logic [7:0] data);
    return bus_access(op, addr, data, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endfunction

  function automatic in_item_t random_access();
    int unsigned pick;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    op   = 1'($urandom_range(0, 1));
    data = 8'($urandom);
    if (pick < 12) begin
      op   = OP_WRITE;
      addr = 16'($urandom_range(0, 'h7fff));
      if ($urandom_range(0, 1) != 0) data[3:0] = 4'ha;
    end else if (pick < 27) begin
      op   = OP_READ;
      addr = 16'($urandom_range('h4000, 'h7fff));
    end else if (pick < 40) begin
      addr = 16'($urandom_range('ha000, 'hbfff));
    end else if (pick < 50) begin
      op   = OP_READ;
      addr = 16'($urandom_range(0, 'h0fff));
    end else if (pick < 60) begin
      addr = 16'($urandom_range('h8000, 'h9fff));
    end else if (pick < 70) begin
      addr = 16'($urandom_range('hc000, 'hdfff));
    end else if (pick < 80) begin
      addr = 16'($urandom_range('he000, 'hfdff));
    end else if (pick < 90) begin
      addr = 16'($urandom_range('hfe00, 'hffff));
    end else begin
      addr = 16'($urandom);
    end
    return random_context(op, addr, data);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_access(input in_item_t item);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    cfg_valid = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val[CFG_DATA_W-1:0]);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [1:0] mt, input int unsigned banks,
                                input int unsigned ram_bytes, input logic boot_on,
                                input int unsigned boot_bytes);
    write_reg(CFG_MAPPER_TYPE, mt);
    write_reg(CFG_ROM_BANK_COUNT, banks);
    write_reg(CFG_CART_RAM_BYTES, ram_bytes);
    write_reg(CFG_BOOT_OVERLAY_ON, boot_on);
    write_reg(CFG_BOOT_IMAGE_BYTES, boot_bytes);
    cfg_valid = 1'b0;
    settings_applied++;
  endtask

  // hold the input idle until every prediction has been matched or the wait limit runs out
  task automatic drain();
    int unsigned waited;
    waited   = 0;
    in_valid = 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // enable RAM, pick banks, then hit the banked windows
  task automatic run_bank_sequence();
    logic [7:0] en;
    en = 8'($urandom);
    if ($urandom_range(0, 9) != 0) en[3:0] = 4'ha;
    send_access(random_context(OP_WRITE, 16'($urandom_range(0, 'h1fff)), en));
    send_access(random_context(OP_WRITE, 16'($urandom_range('h2000, 'h2fff)), 8'($urandom)));
    if ($urandom_range(0, 1) != 0)
      send_access(random_context(OP_WRITE, 16'($urandom_range('h3000, 'h3fff)), 8'($urandom)));
    send_access(random_context(OP_WRITE, 16'($urandom_range('h4000, 'h5fff)), 8'($urandom)));
    repeat ($urandom_range(3, 8)) begin
      if ($urandom_range(0, 1) != 0)
        send_access(random_context(OP_READ, 16'($urandom_range('h4000, 'h7fff)),
                                   8'($urandom)));
      else
        send_access(random_context(1'($urandom_range(0, 1)),
                                   16'($urandom_range('ha000, 'hbfff)), 8'($urandom)));
    end
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = accesses_sent + n_items;
    while (accesses_sent < stop_at) begin
      if ($urandom_range(0, 9) < 4) run_bank_sequence();
      else send_access(random_access());
    end
  endtask

  initial begin
    int unsigned kinds;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_valid        = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    rx_mode          = RX_ALWAYS;
    hold_cycles      = 0;
    gaps_on          = 1'b0;
    burst_left       = 0;
    accesses_sent    = 0;
    settings_applied = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: no mapper, two banks, no cartridge RAM, full boot image
    gaps_on = 1'b1;
    send_access(bus_access(OP_READ,  16'h0000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h0100, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h08ff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h4000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h2000, 8'h05, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h7fff, 8'hff, 1'b1, 2'd3, 1'b1, 3'd7));
    send_access(bus_access(OP_READ,  16'h8000, 8'h00, 1'b1, 2'd3, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h9fff, 8'hff, 1'b1, 2'd2, 1'b1, 3'd0));
    send_access(bus_access(OP_READ,  16'h8000, 8'h00, 1'b0, 2'd3, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'ha000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'hd000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'hdfff, 8'haa, 1'b0, 2'd0, 1'b0, 3'd7));
    send_access(bus_access(OP_READ,  16'he000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd3));
    send_access(bus_access(OP_READ,  16'hfdff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'hfea0, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'hff7f, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'hff80, 8'h55, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'hffff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    drain();

    // MBC5: bank zero, ninth bank bit, RAM bank 15, enable and disable
    apply_settings(MAP_MBC5, 300, 32768, 1'b1, 2304);
    send_access(bus_access(OP_WRITE, 16'h0000, 8'h0a, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h2000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h4000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h3000, 8'h01, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h7fff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h4000, 8'h0f, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'hbfff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h1fff, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'ha000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    drain();

    // MBC1: a zero bank field selects bank one; short boot image
    apply_settings(MAP_MBC1, 32, 8192, 1'b1, 256);
    send_access(bus_access(OP_WRITE, 16'h2000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h4000, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_WRITE, 16'h3fff, 8'he0, 1'b0, 2'd0, 1'b0, 3'd0));
    send_access(bus_access(OP_READ,  16'h0200, 8'h00, 1'b0, 2'd0, 1'b0, 3'd0));
    rx_mode = RX_RANDOM;
    run_random_phase(PHASE_ITEMS);
    drain();

    // largest sizes; the receiver holds off while the sender keeps pushing
    apply_settings(MAP_MBC5, 512, 131072, 1'b0, 2304);
    gaps_on     = 1'b0;
    rx_mode     = RX_ALWAYS;
    hold_cycles = LONG_HOLD;
    run_random_phase(PHASE_ITEMS);
    drain();

    // bank count of zero, oversized RAM, largest boot image value
    apply_settings(MAP_MBC5, 0, 'h3ffff, 1'b1, 'hfff);
    gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    run_random_phase(PHASE_ITEMS);
    drain();

    // unused mapper code, bank count above the limit, one byte of RAM, no boot image
    for (int i = CFG_BOOT_IMAGE_BYTES + 1; i < (1 << CFG_ADDR_W); i++)
      write_reg(CFG_ADDR_W'(i), 'h3ffff);
    cfg_valid = 1'b0;
    apply_settings(2'd3, 'h3ffff, 1, 1'b1, 0);
    rx_mode = RX_RANDOM;
    run_random_phase(PHASE_ITEMS);
    drain();

    // bank count and RAM size that are not powers of two, so the remainder is not a mask
    apply_settings(MAP_MBC1, 3, 24576, 1'b1, 2304);
    gaps_on = 1'b0;
    rx_mode = RX_PATTERN;
    run_random_phase(PHASE_ITEMS);
    drain();

    // small cartridge: two banks, no RAM, overlay off
    apply_settings(MAP_MBC5, 2, 0, 1'b0, 'h250);
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    run_random_phase(PHASE_ITEMS);
    drain();

    if (sb.pending() != 0) begin
      $error("%0d predicted results never arrived", sb.pending());
      sb.n_errors++;
    end
    kinds = 0;
    foreach (sb.target_seen[i]) if (sb.target_seen[i] != 0) kinds++;
    $display("Decoded %0d bus transactions, %0d results checked, over %0d register settings",
             accesses_sent, sb.n_checked, settings_applied);
    $display("Distinct targets reached: %0d, with gaps, stalls and one long output hold",
             kinds);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
